// ===== rtl/core/vsa_pkg.sv =====
// Shared types, constants and coefficients of the vectorscope accumulator.
`timescale 1ns / 1ps

package vsa_pkg;

   // Store geometry: square plot, row stride of one scope line
   localparam int SCOPE_SIZE  = 512;
   localparam int COORD_W     = 9;
   localparam int CELL_AW     = $clog2(SCOPE_SIZE);
   localparam int STORE_AW    = 2 * CELL_AW;
   localparam int STORE_DEPTH = SCOPE_SIZE * SCOPE_SIZE;

   // Field widths
   localparam int MODE_W    = 2;
   localparam int CHAN_W    = 12;
   localparam int CELL_W    = 13;
   localparam int CELL_DW   = 3 * CELL_W;
   localparam int CFG_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int INC_W     = 9;

   // Chroma arithmetic: Q1.14 coefficients times 12-bit fractions, 2^-26 weight
   localparam int PROD_W     = 28;
   localparam int PSC_W      = PROD_W + 8;
   localparam int FRAC_SHIFT = 26;
   localparam int POS_W      = 12;

   localparam logic signed [PROD_W-1:0] COEF_UR = -28'sd1637;
   localparam logic signed [PROD_W-1:0] COEF_UG = -28'sd5506;
   localparam logic signed [PROD_W-1:0] COEF_UB =  28'sd7143;
   localparam logic signed [PROD_W-1:0] COEF_VR =  28'sd10076;
   localparam logic signed [PROD_W-1:0] COEF_VG = -28'sd9152;
   localparam logic signed [PROD_W-1:0] COEF_VB = -28'sd924;

   // floor(c / 10) as (c * 3277) >> 15, exact for 12-bit c
   localparam int TENTH_SHIFT  = 15;
   localparam int TENTH_PROD_W = 24;
   localparam logic [TENTH_PROD_W-1:0] TENTH_MUL = 24'd3277;

   // Cell limits
   localparam logic [CELL_W-1:0] CELL_ONE = 13'd4096;
   localparam logic [CELL_W-1:0] CELL_MAX = 13'd4504;

   // Configuration
   localparam logic [CFG_W-1:0]     CFG_RESET      = 10'd512;
   localparam logic [CFG_W-1:0]     SCOPE_LIMIT    = CFG_W'(SCOPE_SIZE);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_HEIGHT = 2'd1;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_PLOT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_EMPTY,
      OP_PLOT,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [INC_W-1:0]   inc_r;
      logic [INC_W-1:0]   inc_g;
      logic [INC_W-1:0]   inc_b;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_LOOKUP
   } back_state_type;

endpackage

// ===== rtl/core/vsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vsa_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/vsa_front.sv =====
// Front end: CSRs, chroma computation and classification of each transaction.
`timescale 1ns / 1ps

module vsa_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [vsa_pkg::MODE_W-1:0]      req_mode,
   input  logic [vsa_pkg::CHAN_W-1:0]      req_red,
   input  logic [vsa_pkg::CHAN_W-1:0]      req_green,
   input  logic [vsa_pkg::CHAN_W-1:0]      req_blue,
   input  logic [vsa_pkg::COORD_W-1:0]     req_cell_x,
   input  logic [vsa_pkg::COORD_W-1:0]     req_cell_y,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vsa_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                            sweeping,
   input  logic                            q_full,
   output logic                            q_push,
   output vsa_pkg::cmd_type                q_cmd
);
   import vsa_pkg::*;

   // CSRs
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;

   // Stage 1: products and increments
   logic                     s1_valid_ff, s1_valid_in;
   logic [MODE_W-1:0]        s1_mode_ff;
   logic signed [PROD_W-1:0] s1_pu_r_ff, s1_pu_g_ff, s1_pu_b_ff;
   logic signed [PROD_W-1:0] s1_pv_r_ff, s1_pv_g_ff, s1_pv_b_ff;
   logic [INC_W-1:0]         s1_inc_r_ff, s1_inc_g_ff, s1_inc_b_ff;
   logic [COORD_W-1:0]       s1_x_ff, s1_y_ff;

   // Stage 2: chroma sums
   logic                     s2_valid_ff, s2_valid_in;
   logic [MODE_W-1:0]        s2_mode_ff;
   logic signed [PROD_W-1:0] s2_su_ff, s2_sv_ff;
   logic [INC_W-1:0]         s2_inc_r_ff, s2_inc_g_ff, s2_inc_b_ff;
   logic [COORD_W-1:0]       s2_x_ff, s2_y_ff;

   logic                     advance;
   logic                     accept;
   logic signed [PROD_W-1:0] red_s, green_s, blue_s;
   logic [TENTH_PROD_W-1:0]  tenth_r, tenth_g, tenth_b;
   logic signed [PSC_W-1:0]  scaled_u, scaled_v;
   logic signed [POS_W-1:0]  off_u, off_v;
   logic [CFG_W-1:0]         active_w, active_h;
   logic signed [POS_W-1:0]  pos_x, pos_y;
   logic                     in_scope;
   logic                     cell_ok;

   assign csr_ready = 1'b1;

   // CSR write decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IDX_WIDTH:  width_in  = csr_wdata;
            CSR_IDX_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Pipeline moves as one unless the last stage is blocked by a full queue
   assign advance   = !(s2_valid_ff && q_full);
   assign req_ready = advance && !sweeping;
   assign accept    = req_valid && req_ready;
   assign q_push    = s2_valid_ff && !q_full;

   assign s1_valid_in = advance ? accept : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage 1 products
   assign red_s   = PROD_W'($signed({1'b0, req_red}));
   assign green_s = PROD_W'($signed({1'b0, req_green}));
   assign blue_s  = PROD_W'($signed({1'b0, req_blue}));
   assign tenth_r = TENTH_PROD_W'(req_red) * TENTH_MUL;
   assign tenth_g = TENTH_PROD_W'(req_green) * TENTH_MUL;
   assign tenth_b = TENTH_PROD_W'(req_blue) * TENTH_MUL;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_mode;
         s1_pu_r_ff  <= COEF_UR * red_s;
         s1_pu_g_ff  <= COEF_UG * green_s;
         s1_pu_b_ff  <= COEF_UB * blue_s;
         s1_pv_r_ff  <= COEF_VR * red_s;
         s1_pv_g_ff  <= COEF_VG * green_s;
         s1_pv_b_ff  <= COEF_VB * blue_s;
         s1_inc_r_ff <= tenth_r[TENTH_SHIFT +: INC_W];
         s1_inc_g_ff <= tenth_g[TENTH_SHIFT +: INC_W];
         s1_inc_b_ff <= tenth_b[TENTH_SHIFT +: INC_W];
         s1_x_ff     <= req_cell_x;
         s1_y_ff     <= req_cell_y;
      end
   end

   // Stage 2 sums
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_su_ff    <= s1_pu_r_ff + s1_pu_g_ff + s1_pu_b_ff;
         s2_sv_ff    <= s1_pv_r_ff + s1_pv_g_ff + s1_pv_b_ff;
         s2_inc_r_ff <= s1_inc_r_ff;
         s2_inc_g_ff <= s1_inc_g_ff;
         s2_inc_b_ff <= s1_inc_b_ff;
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
      end
   end

   // Offset = floor(S * 255 / 2^26); arithmetic shift floors toward minus infinity
   assign scaled_u = (PSC_W'(s2_su_ff) <<< 8) - PSC_W'(s2_su_ff);
   assign scaled_v = (PSC_W'(s2_sv_ff) <<< 8) - PSC_W'(s2_sv_ff);
   assign off_u    = POS_W'(scaled_u >>> FRAC_SHIFT);
   assign off_v    = POS_W'(scaled_v >>> FRAC_SHIFT);

   // Oversized register acts as the full scope
   assign active_w = (width_ff > SCOPE_LIMIT) ? SCOPE_LIMIT : width_ff;
   assign active_h = (height_ff > SCOPE_LIMIT) ? SCOPE_LIMIT : height_ff;

   assign pos_x = $signed({{(POS_W - CFG_W + 1){1'b0}}, active_w[CFG_W-1:1]}) + off_u;
   assign pos_y = $signed({{(POS_W - CFG_W + 1){1'b0}}, active_h[CFG_W-1:1]}) + off_v;

   assign in_scope = (pos_x > 0) && (pos_x < $signed({{(POS_W - CFG_W){1'b0}}, active_w}))
                  && (pos_y > 0) && (pos_y < $signed({{(POS_W - CFG_W){1'b0}}, active_h}));

   // Read and clear only address cells that exist in the store
   assign cell_ok = (int'(s2_x_ff) < SCOPE_SIZE) && (int'(s2_y_ff) < SCOPE_SIZE);

   // Classification into a back-end command
   always_comb begin
      q_cmd = '0;
      q_cmd.op = OP_EMPTY;
      case (s2_mode_ff)
         MODE_PLOT: begin
            if (in_scope) begin
               q_cmd.op    = OP_PLOT;
               q_cmd.x     = pos_x[COORD_W-1:0];
               q_cmd.y     = pos_y[COORD_W-1:0];
               q_cmd.inc_r = s2_inc_r_ff;
               q_cmd.inc_g = s2_inc_g_ff;
               q_cmd.inc_b = s2_inc_b_ff;
            end
         end
         MODE_READ: begin
            if (cell_ok) begin
               q_cmd.op = OP_READ;
               q_cmd.x  = s2_x_ff;
               q_cmd.y  = s2_y_ff;
            end
         end
         MODE_CLEAR: begin
            if (cell_ok) begin
               q_cmd.op = OP_CLEAR;
               q_cmd.x  = s2_x_ff;
               q_cmd.y  = s2_y_ff;
            end
         end
         default: ;
      endcase
   end

   // A plotted point never lands on the border row or column
   a_plot_inside: assert property (@(posedge clock) disable iff (reset)
      q_push && q_cmd.op == OP_PLOT |-> q_cmd.x != '0 && q_cmd.y != '0)
      else $error("plot command on scope border");

endmodule

// ===== rtl/core/vsa_queue.sv =====
// Short command queue between the front end and the store back end.
`timescale 1ns / 1ps

module vsa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vsa_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output vsa_pkg::cmd_type head_cmd
);
   import vsa_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command queue underflow");

endmodule

// ===== rtl/core/vsa_back.sv =====
// Back end: store sweep after reset, cell read-modify-write and result register.
`timescale 1ns / 1ps

module vsa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  vsa_pkg::cmd_type              q_head,
   output logic                          q_pop,
   output logic                          sweeping,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [vsa_pkg::COORD_W-1:0]   rsp_plot_x,
   output logic [vsa_pkg::COORD_W-1:0]   rsp_plot_y,
   output logic [vsa_pkg::CELL_W-1:0]    rsp_cell_red,
   output logic [vsa_pkg::CELL_W-1:0]    rsp_cell_green,
   output logic [vsa_pkg::CELL_W-1:0]    rsp_cell_blue
);
   import vsa_pkg::*;

   back_state_type      state_ff, state_in;
   logic [STORE_AW-1:0] sweep_addr_ff, sweep_addr_in;
   cmd_type             cmd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [COORD_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [CELL_W-1:0]   rsp_r_ff, rsp_g_ff, rsp_b_ff;

   logic                finish;
   logic                rd_en;
   logic [STORE_AW-1:0] rd_addr;
   logic                wr_en;
   logic [STORE_AW-1:0] wr_addr;
   logic [CELL_DW-1:0]  wr_data;
   logic [CELL_DW-1:0]  rd_data;
   logic [CELL_W-1:0]   old_r, old_g, old_b;
   logic [CELL_W-1:0]   new_r, new_g, new_b;
   logic                room;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_SWEEP:  if (sweep_addr_ff == '1) state_in = BK_IDLE;
         BK_IDLE:   if (q_valid) state_in = BK_LOOKUP;
         BK_LOOKUP: if (!rsp_valid_ff || rsp_ready) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      sweeping = 1'b0;
      q_pop    = 1'b0;
      finish   = 1'b0;
      case (state_ff)
         BK_SWEEP:  sweeping = 1'b1;
         BK_IDLE:   q_pop    = q_valid;
         BK_LOOKUP: finish   = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign sweep_addr_in = (state_ff == BK_SWEEP) ? sweep_addr_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_SWEEP;
         sweep_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_head;
      end
   end

   // Store lookup is issued as the command leaves the queue
   assign rd_en   = q_pop;
   assign rd_addr = {q_head.y[CELL_AW-1:0], q_head.x[CELL_AW-1:0]};

   // Cell update: grows only while every channel is below one
   assign {old_r, old_g, old_b} = rd_data;
   assign room = (old_r < CELL_ONE) && (old_g < CELL_ONE) && (old_b < CELL_ONE);

   always_comb begin
      new_r = '0;
      new_g = '0;
      new_b = '0;
      case (cmd_ff.op)
         OP_PLOT: begin
            new_r = room ? old_r + CELL_W'(cmd_ff.inc_r) : old_r;
            new_g = room ? old_g + CELL_W'(cmd_ff.inc_g) : old_g;
            new_b = room ? old_b + CELL_W'(cmd_ff.inc_b) : old_b;
         end
         OP_READ: begin
            new_r = old_r;
            new_g = old_g;
            new_b = old_b;
         end
         default: ;
      endcase
   end

   // Write port: zero sweep after reset, then write-back of plot and clear
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {cmd_ff.y[CELL_AW-1:0], cmd_ff.x[CELL_AW-1:0]};
      wr_data = {new_r, new_g, new_b};
      if (state_ff == BK_SWEEP) begin
         wr_en   = 1'b1;
         wr_addr = sweep_addr_ff;
         wr_data = '0;
      end else if (finish && (cmd_ff.op == OP_PLOT || cmd_ff.op == OP_CLEAR)) begin
         wr_en = 1'b1;
      end
   end

   vsa_ram #(
      .DATA_W (CELL_DW),
      .DEPTH  (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result register
   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_hit_ff <= (cmd_ff.op == OP_PLOT);
         rsp_x_ff   <= cmd_ff.x;
         rsp_y_ff   <= cmd_ff.y;
         rsp_r_ff   <= new_r;
         rsp_g_ff   <= new_g;
         rsp_b_ff   <= new_b;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_plot_x     = rsp_x_ff;
   assign rsp_plot_y     = rsp_y_ff;
   assign rsp_cell_red   = rsp_r_ff;
   assign rsp_cell_green = rsp_g_ff;
   assign rsp_cell_blue  = rsp_b_ff;

   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == BK_LOOKUP)
      else $error("result appeared without a store lookup");

   a_hit_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_x_ff != '0 && rsp_y_ff != '0)
      else $error("hit reported on scope border");

   a_cell_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_r_ff <= CELL_MAX && rsp_g_ff <= CELL_MAX && rsp_b_ff <= CELL_MAX)
      else $error("cell value beyond saturation bound");

endmodule

// ===== rtl/core/vectorscope_accumulator_top.sv =====
// Top level of the vectorscope accumulator: front end, command queue and back end.
`timescale 1ns / 1ps

// Plots RGB pixels on a UV vectorscope held in a 512 x 512 store of three
// 13-bit cells. After reset the store is zeroed by a sweep over all 262144
// addresses (one per clock) during which req_ready is low; CSR writes are
// taken throughout. The front end computes chroma and classifies each
// transaction in a two-stage pipeline, then hands a command through a
// four-entry queue to the back end. The back end reads the addressed cell,
// updates it and writes it back, and finishes each transaction before it
// pops the next command. A request passes through stage 1, stage 2, the
// queue, the back end's command register and store read, and the result
// register before rsp_valid rises. A finished result waits in an output
// register while further requests are accepted into the pipeline and queue.
module vectorscope_accumulator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [vsa_pkg::MODE_W-1:0]    req_mode,
   input  logic [vsa_pkg::CHAN_W-1:0]    req_red,
   input  logic [vsa_pkg::CHAN_W-1:0]    req_green,
   input  logic [vsa_pkg::CHAN_W-1:0]    req_blue,
   input  logic [vsa_pkg::COORD_W-1:0]   req_cell_x,
   input  logic [vsa_pkg::COORD_W-1:0]   req_cell_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [vsa_pkg::COORD_W-1:0]   rsp_plot_x,
   output logic [vsa_pkg::COORD_W-1:0]   rsp_plot_y,
   output logic [vsa_pkg::CELL_W-1:0]    rsp_cell_red,
   output logic [vsa_pkg::CELL_W-1:0]    rsp_cell_green,
   output logic [vsa_pkg::CELL_W-1:0]    rsp_cell_blue,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vsa_pkg::CFG_W-1:0]     csr_wdata
);
   import vsa_pkg::*;

   logic    sweeping;
   logic    q_full;
   logic    q_push;
   cmd_type q_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_head;

   vsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .req_cell_x (req_cell_x),
      .req_cell_y (req_cell_y),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sweeping   (sweeping),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   vsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   vsa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .sweeping       (sweeping),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_plot_x     (rsp_plot_x),
      .rsp_plot_y     (rsp_plot_y),
      .rsp_cell_red   (rsp_cell_red),
      .rsp_cell_green (rsp_cell_green),
      .rsp_cell_blue  (rsp_cell_blue)
   );

endmodule
